// ===== hw/rtl/tcw_pkg.sv =====
// tcw_pkg: shared types and constants of the text console writer
// screen geometry, operation and register codes, transfer payload structs
// no dependencies
package tcw_pkg;

    // screen geometry
    localparam int unsigned COLUMNS = 80;
    localparam int unsigned ROWS    = 25;
    localparam int unsigned CELLS   = COLUMNS * ROWS;

    localparam int unsigned COL_W  = $clog2(COLUMNS);
    localparam int unsigned ROW_W  = $clog2(ROWS);
    localparam int unsigned ADDR_W = $clog2(CELLS);

    // fixed field widths
    localparam int unsigned POS_W       = 11;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned ATTR_W      = 8;
    localparam int unsigned CELL_W      = CHAR_W + ATTR_W;
    localparam int unsigned KEYS_W      = 8;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_KEY   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTR  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_LIMIT = 1'd1;

    // character codes and reset values
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
    localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;
    localparam logic [CHAR_W-1:0] SPACE_CHAR     = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h0F;
    localparam logic [KEYS_W-1:0] RESET_LIMIT    = 8'hFF;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] character;
        logic [10:0]       cell_address;
    } tcw_in_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] read_data;
        logic [KEYS_W-1:0] line_index;
        logic              key_stored;
        logic              line_done;
    } tcw_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR,
        ST_DONE
    } tcw_state_t;

endpackage

// ===== hw/rtl/text_console_writer.sv =====
// text_console_writer: text console engine over a character cell memory
// depends on tcw_pkg and tcw_ram
//
// The screen is a ROWS x COLUMNS cell memory, each cell an attribute byte over a character
// byte. After reset the block runs a clearing pass that fills the screen with spaces in
// attribute 0x0F; in_ready stays low during it, while configuration writes are taken at
// any time. One item is worked at a time: an ordinary character, newline without scroll,
// backspace or key goes from the idle state through the done state into the output
// register; a read of a cell on the screen passes through the read state first. A clear
// sweeps every cell once. A scroll goes through the single ram port pair: each row but the
// top is copied up one cell per cycle and the bottom row is blanked. The result is held in
// an output register, so a new item is accepted while the previous result still waits for
// out_ready. cursor_position always reports the cursor after the item, for driving a
// hardware cursor.
module text_console_writer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tcw_pkg::tcw_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tcw_pkg::tcw_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcw_pkg::*;

    // control state
    tcw_state_t        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [KEYS_W-1:0] pend_reg, pend_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;

    // configuration
    logic [ATTR_W-1:0] attr_reg;
    logic [KEYS_W-1:0] limit_reg;

    // staged result fields
    logic [KEYS_W-1:0] res_idx_reg, res_idx_next;
    logic              res_stored_reg, res_stored_next;
    logic              res_done_reg, res_done_next;
    logic [CELL_W-1:0] res_read_reg, res_read_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    tcw_out_t          out_data_reg, out_data_next;

    // screen memory port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    // helpers
    logic [ADDR_W-1:0] cur_pos;
    logic [KEYS_W-1:0] key_top;
    logic [KEYS_W-1:0] key_idx;
    logic              do_draw;
    logic              do_newline;
    logic              at_home;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // linear cell index of the cursor, a multiply by a constant
    assign cur_pos = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLUMNS)) + ADDR_W'(col_reg);
    assign at_home = (row_reg == '0) && (col_reg == '0);

    // a line limit of zero behaves as one
    assign key_top = ((limit_reg == '0) ? KEYS_W'(1) : limit_reg) - KEYS_W'(1);
    assign key_idx = (pend_reg > key_top) ? key_top : pend_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg  <= RESET_ATTR;
            limit_reg <= RESET_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEXT_ATTR:  attr_reg  <= cfg_data;
                REG_LINE_LIMIT: limit_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_idx_reg    <= res_idx_next;
        res_stored_reg <= res_stored_next;
        res_done_reg   <= res_done_next;
        res_read_reg   <= res_read_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        res_idx_next    = res_idx_reg;
        res_stored_next = res_stored_reg;
        res_done_next   = res_done_reg;
        res_read_next   = res_read_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        mem_we          = 1'b0;
        mem_waddr       = cur_pos;
        mem_wdata       = {attr_reg, SPACE_CHAR};
        mem_raddr       = '0;
        do_draw         = 1'b0;
        do_newline      = 1'b0;

        case (state_reg)
            // power-up fill of the whole screen
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {RESET_ATTR, SPACE_CHAR};
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_idx_next    = '0;
                    res_stored_next = 1'b0;
                    res_done_next   = 1'b0;
                    res_read_next   = '0;
                    state_next      = ST_DONE;
                    case (in_data.op)
                        OP_WRITE:
                        begin
                            // backspace is drawn like any glyph here
                            if (in_data.character == NEWLINE_CHAR)
                            begin
                                do_newline = 1'b1;
                            end
                            else
                            begin
                                do_draw = 1'b1;
                            end
                        end

                        OP_KEY:
                        begin
                            if (in_data.character == NEWLINE_CHAR)
                            begin
                                do_newline    = 1'b1;
                                pend_next     = '0;
                                res_done_next = 1'b1;
                            end
                            else if (in_data.character == BACKSPACE_CHAR)
                            begin
                                // erase the previous cell, back across a row edge
                                if ((pend_reg != '0) && !at_home)
                                begin
                                    pend_next = pend_reg - KEYS_W'(1);
                                    mem_we    = 1'b1;
                                    mem_waddr = cur_pos - ADDR_W'(1);
                                    if (col_reg == '0)
                                    begin
                                        col_next = COL_W'(COLUMNS - 1);
                                        row_next = row_reg - ROW_W'(1);
                                    end
                                    else
                                    begin
                                        col_next = col_reg - COL_W'(1);
                                    end
                                end
                            end
                            else
                            begin
                                do_draw         = 1'b1;
                                res_idx_next    = key_idx;
                                res_stored_next = 1'b1;
                                pend_next       = (key_idx < key_top) ?
                                                  key_idx + KEYS_W'(1) : key_idx;
                            end
                        end

                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end

                        OP_READ:
                        begin
                            // out-of-range addresses read as zero
                            if (in_data.cell_address < CELLS)
                            begin
                                mem_raddr  = ADDR_W'(in_data.cell_address);
                                state_next = ST_READ;
                            end
                        end

                        default: ;
                    endcase

                    if (do_draw)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_pos;
                        mem_wdata = {attr_reg, in_data.character};
                        if (col_reg == COL_W'(COLUMNS - 1))
                        begin
                            do_newline = 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end

                    if (do_newline)
                    begin
                        col_next = '0;
                        if (row_reg == ROW_W'(ROWS - 1))
                        begin
                            cnt_next   = '0;
                            state_next = ST_COPY;
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                end
            end

            ST_READ:
            begin
                res_read_next = mem_rdata;
                state_next    = ST_DONE;
            end

            // scroll: read cell n+COLUMNS, write it to cell n in the following cycle
            ST_COPY:
            begin
                if (cnt_reg < ADDR_W'(CELLS - COLUMNS))
                begin
                    mem_raddr = cnt_reg + ADDR_W'(COLUMNS);
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg - ADDR_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (cnt_reg == ADDR_W'(CELLS - COLUMNS))
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            // blank the bottom row, or the whole screen on a clear
            ST_BLANK,
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.cursor_position = POS_W'(cur_pos);
                    out_data_next.read_data       = res_read_reg;
                    out_data_next.line_index      = res_idx_reg;
                    out_data_next.key_stored      = res_stored_reg;
                    out_data_next.line_done       = res_done_reg;
                    out_valid_next                = 1'b1;
                    state_next                    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // cursor never leaves the screen
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= COL_W'(COLUMNS - 1)) && (row_reg <= ROW_W'(ROWS - 1)))
        else $error("cursor outside the screen");

    // key count stays below the largest line limit
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != KEYS_W'(255))
        else $error("pending key count out of range");

    // scroll copy never reads the cell it writes
    a_copy_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && mem_we) |-> (mem_waddr != mem_raddr))
        else $error("scroll copy read and write collide");

    // a new result only comes from the done state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");

    // the ram is written while idle only by an accepted item
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && mem_we) |-> (in_valid && in_ready))
        else $error("screen written while idle without a transfer");
`endif

endmodule

// ===== hw/rtl/tcw_ram.sv =====
// tcw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
